FILE: sv/kts_pkg.sv
package kts_pkg;
    localparam int unsigned MaxKeysDef = 64;
    localparam int unsigned TimeW = 32;
    localparam int unsigned ValW = 32;
    localparam int unsigned StatW = 3;
    localparam int unsigned KindW = 2;
    localparam int unsigned FracW = 16;

    typedef enum logic [KindW-1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_SAMPLE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [StatW-1:0] {
        S_OK     = 3'd0,
        S_EMPTY  = 3'd1,
        S_BEFORE = 3'd2,
        S_PAST   = 3'd3,
        S_FULL   = 3'd4
    } t_status;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_req;
    typedef struct packed {
        logic                 done;
        logic [FracW-1:0]     quot;
    } t_div_rsp;
endpackage

FILE: sv/kts_div.sv
// Restoring divider: quot = floor((num << 16) / den), num < den, one bit per cycle.
module kts_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kts_pkg::t_div_req         i_req,
    input  logic [kts_pkg::TimeW-1:0] i_num,
    input  logic [kts_pkg::TimeW-1:0] i_den,
    output kts_pkg::t_div_rsp         o_rsp
);
    import kts_pkg::*;

    logic [TimeW:0]       r_rem;
    logic [TimeW-1:0]     r_den;
    logic [FracW-1:0]     r_q;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TimeW+1:0]     w_sh;
    logic [TimeW+1:0]     w_diff;

    assign w_sh   = {r_rem, 1'b0};
    assign w_diff = w_sh - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_cnt  <= 5'(FracW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_diff[TimeW+1]) begin
                    r_rem <= w_diff[TimeW:0];
                    r_q   <= {r_q[FracW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[TimeW:0];
                    r_q   <= {r_q[FracW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

FILE: sv/keyframe_track_sampler_unit.sv
// Channel  | Dir | tdata (low bit up)                          | Notes
// s_axis   | in  | time_req[31:0] x[63:32] y[95:64] z[127:96]  | tuser = kind
// m_axis   | out | out_x[31:0] out_y[63:32] out_z[95:64]       | tuser = status
// cfg      | in  | sample_mode                                 | valid/ready
//
// Sample: the scan reads the keys in order, each read registered before its compare,
// then for a linear blend a divide and three multiplies, one per component, on one
// shared 33x17 multiplier.
// Synchronous active-low reset empties the track and clears sample_mode.
// Input tready is low from acceptance until the result has been taken.
module keyframe_track_sampler_unit #(
    parameter int unsigned MAX_KEYS = kts_pkg::MaxKeysDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // time_req, value_x, value_y, value_z
    input  logic [1:0]   s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // out_x, out_y, out_z
    output logic [2:0]   m_axis_tuser,   // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data        // sample_mode
);
    import kts_pkg::*;

    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_SCAN, ST_CHECK, ST_RDB, ST_SEL,
        ST_DIV, ST_MUL, ST_OUT
    } t_state;

    // key memory: time plus three components per row
    logic [TimeW+3*ValW-1:0] r_mem [MAX_KEYS];
    logic [TimeW+3*ValW-1:0] r_rd;
    logic [AW-1:0]           n_raddr;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic                 r_mode;
    logic [1:0]           r_kind;
    logic [TimeW-1:0]     r_t;
    logic [TimeW-1:0]     r_tp;
    logic [3*ValW-1:0]    r_vp;
    logic [3*ValW-1:0]    r_va;
    logic [3*ValW-1:0]    r_res;
    logic [StatW-1:0]     r_stat;
    logic                 r_ovalid;
    logic [1:0]           r_lane;
    logic                 r_rdp;   // read latency phase
    logic [FracW-1:0]     r_frac;
    logic signed [ValW+FracW+1:0] r_prod;
    logic                 r_pv;

    t_div_req             w_dreq;
    t_div_rsp             w_drsp;
    logic [TimeW-1:0]     w_ta;

    assign w_ta = r_rd[TimeW-1:0];

    // divide starts on the edge that leaves the select step
    assign w_dreq.start = (r_state == ST_SEL) && !r_mode;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid && s_axis_tready
            && s_axis_tuser == K_APPEND && r_count < CW'(MAX_KEYS))
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        r_rd <= r_mem[n_raddr];
    end

    always_comb begin
        n_raddr = r_idx[AW-1:0];
    end

    kts_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .i_num  (r_t - r_tp),
        .i_den  (w_ta - r_tp),
        .o_rsp  (w_drsp)
    );

    // shared multiplier: diff (33b signed) times frac (17b)
    logic signed [ValW:0]  w_diff;
    logic [ValW-1:0]       w_vp_l;
    logic [ValW-1:0]       w_va_l;
    assign w_vp_l = r_vp[r_lane*ValW +: ValW];
    assign w_va_l = r_va[r_lane*ValW +: ValW];
    assign w_diff = $signed({w_va_l[ValW-1], w_va_l}) - $signed({w_vp_l[ValW-1], w_vp_l});

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (cfg_valid) r_mode <= cfg_data;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind  <= s_axis_tuser;
                        r_t     <= s_axis_tdata[TimeW-1:0];
                        r_idx   <= '0;
                        r_res   <= '0;
                        r_stat  <= S_OK;
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    case (r_kind)
                        K_CLEAR: begin
                            r_count <= '0;
                            r_state <= ST_OUT;
                        end
                        K_APPEND: begin
                            if (r_count < CW'(MAX_KEYS)) r_count <= r_count + 1'b1;
                            else r_stat <= S_FULL;
                            r_state <= ST_OUT;
                        end
                        K_SAMPLE: begin
                            if (r_count == '0) begin
                                r_stat  <= S_EMPTY;
                                r_state <= ST_OUT;
                            end else begin
                                r_rdp   <= 1'b0;
                                r_state <= ST_SCAN;
                            end
                        end
                        default: r_state <= ST_OUT;
                    endcase
                end
                ST_SCAN: begin
                    // r_rd is registered: valid in the cycle after the address is set
                    if (!r_rdp) begin
                        r_rdp <= 1'b1;
                    end else if (r_count == CW'(1)) begin
                        r_res   <= r_rd[TimeW +: 3*ValW];
                        r_state <= ST_OUT;
                    end else if (w_ta > r_t) begin
                        r_state <= ST_CHECK;
                    end else begin
                        r_tp  <= w_ta;
                        r_vp  <= r_rd[TimeW +: 3*ValW];
                        r_rdp <= 1'b0;
                        if (r_idx + 1'b1 == r_count) begin
                            r_stat  <= S_PAST;
                            r_state <= ST_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_CHECK: begin
                    if (r_idx == '0) begin
                        r_stat  <= S_BEFORE;
                        r_state <= ST_OUT;
                    end else begin
                        r_va    <= r_rd[TimeW +: 3*ValW];
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (r_mode) begin
                        r_res   <= ((r_t - r_tp) > (w_ta - r_t)) ? r_va : r_vp;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_drsp.done) begin
                        r_frac  <= w_drsp.quot;
                        r_lane  <= 2'd0;
                        r_pv    <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!r_pv) begin
                        r_prod <= w_diff * $signed({1'b0, r_frac});
                        r_pv   <= 1'b1;
                    end else begin
                        r_res[r_lane*ValW +: ValW] <= w_vp_l
                            + r_prod[FracW +: ValW];
                        r_pv <= 1'b0;
                        if (r_lane == 2'd2) r_state <= ST_OUT;
                        else r_lane <= r_lane + 2'd1;
                    end
                end
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb_keyframe_track_sampler_unit.sv
module tb_keyframe_track_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import kts_pkg::*;

    localparam int NKEYS = 64;

    // one sampled result: status plus three components
    typedef struct {
        t_status     status;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_sample;

    // Track model and queue of pending results, checked in order.
    class track_scoreboard;
        logic [31:0] times[NKEYS];
        logic [31:0] vx[NKEYS];
        logic [31:0] vy[NKEYS];
        logic [31:0] vz[NKEYS];
        int          count;
        bit          nearest;
        t_sample     pending[$];
        int          errors;

        function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                              logic [15:0] frac);
            longint diff;
            longint prod;
            longint q;
            diff = longint'($signed(b)) - longint'($signed(a));
            prod = diff * longint'({1'b0, frac});
            q = prod >>> 16;   // arithmetic shift floors toward minus infinity
            return 32'(longint'($signed(a)) + q);
        endfunction

        function void note_request(t_kind kind, logic [31:0] t, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z);
            t_sample r;
            int i;
            logic [31:0] ahead;
            logic [31:0] behind;
            logic [63:0] num;
            logic [15:0] frac;
            r = '{S_OK, 32'd0, 32'd0, 32'd0};
            case (kind)
                K_CLEAR: count = 0;
                K_APPEND: begin
                    if (count >= NKEYS) begin
                        r.status = S_FULL;
                    end else begin
                        times[count] = t;
                        vx[count] = x;
                        vy[count] = y;
                        vz[count] = z;
                        count++;
                    end
                end
                K_SAMPLE: begin
                    if (count == 0) begin
                        r.status = S_EMPTY;
                    end else if (count == 1) begin
                        r.x = vx[0];
                        r.y = vy[0];
                        r.z = vz[0];
                    end else begin
                        for (i = 0; i < count; i++)
                            if (times[i] > t) break;
                        if (i == 0) begin
                            r.status = S_BEFORE;
                        end else if (i >= count) begin
                            r.status = S_PAST;
                        end else begin
                            ahead = t - times[i-1];
                            behind = times[i] - t;
                            if (!nearest) begin
                                num = {16'd0, ahead, 16'd0};
                                frac = 16'(num / {32'd0, times[i] - times[i-1]});
                                r.x = blend(vx[i-1], vx[i], frac);
                                r.y = blend(vy[i-1], vy[i], frac);
                                r.z = blend(vz[i-1], vz[i], frac);
                            end else if (ahead > behind) begin
                                r.x = vx[i];
                                r.y = vy[i];
                                r.z = vz[i];
                            end else begin
                                r.x = vx[i-1];
                                r.y = vy[i-1];
                                r.z = vz[i-1];
                            end
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [95:0] d);
            t_sample e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result st=%0d data=%h", $time, st, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || d !== {e.z, e.y, e.x}) begin
                $display("%0t: mismatch exp st=%0d %h %h %h got st=%0d %h %h %h",
                         $time, e.status, e.x, e.y, e.z, st, d[31:0], d[63:32],
                         d[95:64]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    track_scoreboard sb = new();
    int  send_idle_pct = 6;    // sender gap odds, percent
    int  recv_idle_pct = 56;   // receiver stall odds, percent
    int  hold_off = 0;         // cycles of forced receiver stall still to go
    logic [31:0] last_time = 0;

    always #6 i_clk = ~i_clk;

    keyframe_track_sampler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Receiver: checks at the rising edge, picks tready at the falling edge.
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one request; idle gaps come before it, valid stays up until taken.
    task automatic send_request(t_kind kind, logic [31:0] t, logic [31:0] x,
                                logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {z, y, x, t};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, t, x, y, z);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait for the block to drain, then write sample_mode.
    task automatic write_mode(bit mode);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge i_clk); while (!cfg_ready);
        sb.nearest = mode;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // A track: clear, keys in non-decreasing time order, then samples, mostly inside it.
    task automatic run_track(int nkeys, int nsamples);
        logic [31:0] t;
        logic [31:0] lo;
        send_request(K_CLEAR, 0, 0, 0, 0);
        t = $urandom_range(3) == 0 ? $urandom() : $urandom_range(1000);
        lo = t;
        for (int k = 0; k < nkeys; k++) begin
            send_request(K_APPEND, t, rand_val(), rand_val(), rand_val());
            last_time = t;
            if ($urandom_range(9) == 0) t = t + 32'd1;
            else if ($urandom_range(3) == 0) t = t + $urandom_range(32'h0100_0000);
            else t = t + $urandom_range(1, 300000);
            if (t < last_time) t = 32'hffff_ffff;   // wrapped: later keys are ties
        end
        for (int s = 0; s < nsamples; s++) begin
            case ($urandom_range(7))
                0: t = $urandom();
                1: t = lo - 1;
                2: t = last_time;
                default: t = lo + $urandom_range(last_time - lo);
            endcase
            send_request(K_SAMPLE, t, $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        int nsent;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty track, single key, bounds, ties, full table, kind 3
        send_request(K_SAMPLE, 0, 0, 0, 0);
        send_request(K_APPEND, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd5);
        send_request(K_SAMPLE, 32'hffff_ffff, 0, 0, 0);
        send_request(K_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff, -32'sd5);
        send_request(K_SAMPLE, 32'h0000_0000, 0, 0, 0);
        send_request(K_SAMPLE, 32'h0001_0000, 0, 0, 0);
        send_request(K_SAMPLE, 32'h0002_0000, 0, 0, 0);
        send_request(K_SAMPLE, 32'h0002_ffff, 0, 0, 0);
        send_request(K_SAMPLE, 32'h0003_0000, 0, 0, 0);
        send_request(K_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(K_APPEND, 32'h0002_0000, 32'd1, 32'd2, 32'd3);   // out of order
        send_request(K_SAMPLE, 32'h0002_8000, 0, 0, 0);
        write_mode(1'b1);
        send_request(K_SAMPLE, 32'h0002_0000, 0, 0, 0);   // tie goes to earlier key
        send_request(K_SAMPLE, 32'h0002_0001, 0, 0, 0);
        send_request(K_SAMPLE, 32'h0001_ffff, 0, 0, 0);
        for (int k = 0; k < NKEYS + 1; k++)   // fill the table, then append past full
            send_request(K_APPEND, 32'h0004_0000 + k, k, -k, k);
        send_request(K_SAMPLE, 32'h0004_0020, 0, 0, 0);
        send_request(K_CLEAR, 0, 0, 0, 0);
        write_mode(1'b0);

        // random tracks across idling phases and both modes
        nsent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 56;
                recv_idle_pct = 6;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int mode = 0; mode < 2; mode++) begin
                write_mode(mode[0]);
                if (phase == 0 && mode == 0) hold_off = 400;
                for (int n = 0; n < 220; ) begin
                    int nk;
                    int ns;
                    if ($urandom_range(9) == 0) begin
                        // noise: unordered or junk requests
                        send_request(t_kind'($urandom_range(3)), $urandom(),
                                     $urandom(), $urandom(), $urandom());
                        n++;
                    end else begin
                        nk = ($urandom_range(19) == 0) ? $urandom_range(60, 66)
                                                       : $urandom_range(8);
                        ns = $urandom_range(1, 10);
                        run_track(nk, ns);
                        n += nk + ns + 1;
                    end
                end
            end
        end

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_keyframe_track_sampler_unit OK");
        else
            $display("tb_keyframe_track_sampler_unit NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_keyframe_track_sampler_unit NOT OK");
        $finish;
    end
endmodule
